[rtl/core/sia_pkg.sv]
package sia_pkg;

	localparam int SLOT_W      = 10;
	localparam int ACTION_W    = 3;
	localparam int SEL_W       = 4;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 11;
	localparam int CFG_MAX_W   = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int FIRST_SLOT  = 1;

	// Statistics counter bank.
	localparam int NUM_CNT        = 11;
	localparam int CNT_PA_CALLS   = 0;
	localparam int CNT_PA_OK      = 1;
	localparam int CNT_PA_OOM     = 2;
	localparam int CNT_PF_CALLS   = 3;
	localparam int CNT_PF_OK      = 4;
	localparam int CNT_NA_CALLS   = 5;
	localparam int CNT_NA_OK      = 6;
	localparam int CNT_NA_OOM     = 7;
	localparam int CNT_NF_CALLS   = 8;
	localparam int CNT_NF_OK      = 9;
	localparam int CNT_BUDGET_REJ = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BACKED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIVE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OOM       = 2'd1,
		ST_INVALID   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PAGE_ALLOC    = 3'd0,
		ACT_PAGE_FREE     = 3'd1,
		ACT_NODE_ALLOC    = 3'd2,
		ACT_NODE_FREE     = 3'd3,
		ACT_RESOLVE       = 3'd4,
		ACT_READ_COUNTER  = 3'd5,
		ACT_RESET_COUNTER = 3'd6
	} action_t;

	typedef struct packed {
		logic               start;
		logic               clear;
		logic [NUM_CNT-1:0] mask;
	} stats_ctl_t;

endpackage

[rtl/core/sia_ram.sv]
module sia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/sia_stats.sv]
module sia_stats #(
	parameter int COUNTER_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sia_pkg::stats_ctl_t       ctl,
	input  logic [sia_pkg::SEL_W-1:0] sel,
	output logic [COUNTER_BITS-1:0]   value,
	output logic                      busy
);

	import sia_pkg::*;

	logic [NUM_CNT-1:0]      pending_q;
	logic [NUM_CNT-1:0]      valid_q;
	logic                    phase_q;
	logic [SEL_W-1:0]        idx_q;
	logic [SEL_W-1:0]        rd_idx_q;
	logic [SEL_W-1:0]        low_idx;
	logic [SEL_W-1:0]        rd_addr;
	logic [COUNTER_BITS-1:0] rdata;
	logic                    wr_en;

	always_comb begin
		low_idx = '0;
		for (int i = NUM_CNT - 1; i >= 0; i--) begin
			if (pending_q[i]) begin
				low_idx = SEL_W'(i);
			end
		end
	end

	assign busy = (pending_q != '0);

	// The read port follows pending bumps first, then the selected counter.
	always_comb begin
		if (busy) begin
			rd_addr = low_idx;
		end else if (sel < SEL_W'(NUM_CNT)) begin
			rd_addr = sel;
		end else begin
			rd_addr = '0;
		end
	end

	// A counter that was never written since the last clear reads as zero.
	assign value = valid_q[rd_idx_q] ? rdata : '0;
	assign wr_en = busy && phase_q;

	sia_ram #(
		.WIDTH(COUNTER_BITS),
		.DEPTH(NUM_CNT),
		.AW   (SEL_W)
	) u_cnt_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_q),
		.wdata(value + COUNTER_BITS'(1)),
		.re   (1'b1),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			valid_q   <= '0;
			phase_q   <= 1'b0;
			idx_q     <= '0;
			rd_idx_q  <= '0;
		end else begin
			rd_idx_q <= rd_addr;
			if (ctl.clear) begin
				valid_q <= '0;
			end
			if (ctl.start) begin
				pending_q <= ctl.mask;
				phase_q   <= 1'b0;
			end else if (busy) begin
				if (!phase_q) begin
					idx_q   <= low_idx;
					phase_q <= 1'b1;
				end else begin
					valid_q[idx_q]   <= 1'b1;
					pending_q[idx_q] <= 1'b0;
					phase_q          <= 1'b0;
				end
			end
		end
	end

endmodule

[rtl/core/slot_id_allocator.sv]
// A word taken in S_IDLE passes S_READ and S_EXEC to S_DONE, which puts its result into the
// output register once that is free. No new word is taken until S_BUMP has bumped the 0..3
// statistics counters of the last; each bump is a read and a write through the single port
// pair of the counter RAM. Reset: asynchronous; a clearing pass over all SLOTS addresses zeroes
// the occupancy memory, with req_stall held high. Configuration writes are taken at all times.
module slot_id_allocator #(
	parameter int SLOTS        = 1024,
	parameter int FREE_DEPTH   = 1024,
	parameter int COUNTER_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [sia_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sia_pkg::CFG_MAX_W-1:0]   cfg_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [sia_pkg::ACTION_W-1:0]    action,
	input  logic [sia_pkg::SLOT_W-1:0]      slot,
	input  logic [sia_pkg::SEL_W-1:0]       counter_select,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [sia_pkg::STATUS_W-1:0]    status,
	output logic [sia_pkg::SLOT_W-1:0]      slot_id,
	output logic                            occupied,
	output logic [COUNTER_BITS-1:0]         counter_value,
	output logic [sia_pkg::COUNT_OUT_W-1:0] active_slots,
	output logic [sia_pkg::COUNT_OUT_W-1:0] high_water
);

	import sia_pkg::*;

	localparam int OAW = $clog2(SLOTS);
	localparam int FAW = $clog2(FREE_DEPTH);
	localparam int FCW = $clog2(FREE_DEPTH + 1);
	localparam int SW  = $clog2(SLOTS + 1);
	localparam int AW2 = (SW > FCW) ? SW : FCW;
	localparam int SCW = (SW > SLOT_W) ? SW : SLOT_W;
	localparam int WW  = (SW > COUNT_OUT_W) ? SW : COUNT_OUT_W;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_READ  = 6'b000100,
		S_EXEC  = 6'b001000,
		S_DONE  = 6'b010000,
		S_BUMP  = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [OAW-1:0]          clr_q;

	action_t                 action_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [SEL_W-1:0]        sel_q;

	logic                    slot_backed_q;
	logic [CFG_MAX_W-1:0]    max_active_q;
	logic [FCW-1:0]          free_count_q;
	logic [SW-1:0]           next_slot_q;
	logic [SW-1:0]           extent_q;
	logic [SW-1:0]           high_q;

	status_t                 res_status_q;
	logic [SLOT_W-1:0]       res_slot_q;
	logic                    res_occ_q;
	logic [COUNTER_BITS-1:0] res_cval_q;
	logic [NUM_CNT-1:0]      mask_q;
	logic                    raise_q;
	logic                    hm_reset_q;

	logic                    rsp_valid_q;
	status_t                 rsp_status_q;
	logic [SLOT_W-1:0]       rsp_slot_q;
	logic                    rsp_occ_q;
	logic [COUNTER_BITS-1:0] rsp_cval_q;
	logic [SW-1:0]           rsp_active_q;
	logic [SW-1:0]           rsp_high_q;

	// Active slot count from the current state.
	logic [AW2-1:0]          ext_a;
	logic [AW2-1:0]          fc_a;
	logic [AW2-1:0]          res_a;
	logic [AW2-1:0]          live_a;
	logic [SW-1:0]           active;

	// Memory ports.
	logic                    occ_we;
	logic [OAW-1:0]          occ_waddr;
	logic                    occ_wdata;
	logic                    occ_rdata;
	logic                    fs_we;
	logic [SLOT_W-1:0]       fs_rdata;

	logic [COUNTER_BITS-1:0] stat_value;
	logic                    stat_busy;
	stats_ctl_t              stat_ctl;

	// Decision logic of the execute step.
	logic                    budget_hit;
	logic                    bump_full;
	logic                    pop_oob;
	logic                    stack_full;
	logic                    slot_hit;
	status_t                 ex_status;
	logic                    ex_occ;
	logic [COUNTER_BITS-1:0] ex_cval;
	logic [NUM_CNT-1:0]      ex_mask;
	logic                    ex_raise;
	logic                    take;
	logic [SW-1:0]           take_slot;
	logic                    push;
	logic                    node_clear;
	logic [FCW-1:0]          fc_nxt;
	logic [SW-1:0]           ns_nxt;
	logic [SW-1:0]           ext_nxt;

	logic                    out_free;
	logic [SW-1:0]           hw_nxt;
	logic [WW-1:0]           act_w;
	logic [WW-1:0]           high_w;

	always_comb begin
		ext_a  = AW2'(extent_q);
		fc_a   = AW2'(free_count_q);
		res_a  = AW2'(slot_backed_q);
		live_a = ext_a - res_a;
		if (ext_a <= res_a) begin
			active = '0;
		end else if (fc_a >= live_a) begin
			active = '0;
		end else begin
			active = SW'(live_a - fc_a);
		end
	end

	assign budget_hit = (max_active_q != '0) && (WW'(active) >= WW'(max_active_q));
	assign bump_full  = (next_slot_q >= SW'(SLOTS));
	assign pop_oob    = (SCW'(fs_rdata) >= SCW'(SLOTS));
	assign stack_full = (free_count_q == FCW'(FREE_DEPTH));
	assign slot_hit   = slot_backed_q && (SCW'(slot_q) < SCW'(extent_q))
		&& (SCW'(slot_q) < SCW'(SLOTS)) && occ_rdata;

	always_comb begin
		ex_status  = ST_OK;
		ex_occ     = 1'b0;
		ex_cval    = '0;
		ex_mask    = '0;
		ex_raise   = 1'b0;
		take       = 1'b0;
		take_slot  = next_slot_q;
		push       = 1'b0;
		node_clear = 1'b0;
		fc_nxt     = free_count_q;
		ns_nxt     = next_slot_q;
		ext_nxt    = extent_q;
		case (action_q)
			ACT_PAGE_ALLOC: begin
				ex_mask[CNT_PA_CALLS] = 1'b1;
				if (budget_hit) begin
					ex_mask[CNT_BUDGET_REJ] = 1'b1;
					ex_mask[CNT_PA_OOM]     = 1'b1;
					ex_status               = ST_OOM;
				end else if (!slot_backed_q) begin
					ex_status = ST_INVALID;
				end else if (free_count_q != '0) begin
					// An out-of-range number stays on the stack.
					if (pop_oob) begin
						ex_mask[CNT_PA_OOM] = 1'b1;
						ex_status           = ST_OOM;
					end else begin
						fc_nxt             = free_count_q - FCW'(1);
						take               = 1'b1;
						take_slot          = SW'(fs_rdata);
						ex_mask[CNT_PA_OK] = 1'b1;
						ex_raise           = 1'b1;
					end
				end else if (bump_full) begin
					ex_mask[CNT_PA_OOM] = 1'b1;
					ex_status           = ST_OOM;
				end else begin
					take               = 1'b1;
					ns_nxt             = next_slot_q + SW'(1);
					ex_mask[CNT_PA_OK] = 1'b1;
					ex_raise           = 1'b1;
				end
			end
			ACT_PAGE_FREE: begin
				ex_mask[CNT_PF_CALLS] = 1'b1;
				if (stack_full) begin
					ex_status = ST_OOM;
				end else begin
					push               = 1'b1;
					fc_nxt             = free_count_q + FCW'(1);
					ex_mask[CNT_PF_OK] = 1'b1;
					ex_raise           = 1'b1;
				end
			end
			ACT_NODE_ALLOC: begin
				ex_mask[CNT_NA_CALLS] = 1'b1;
				if (budget_hit) begin
					ex_mask[CNT_BUDGET_REJ] = 1'b1;
					ex_mask[CNT_NA_OOM]     = 1'b1;
					ex_status               = ST_OOM;
				end else if (!slot_backed_q) begin
					ex_status = ST_INVALID;
				end else if (bump_full) begin
					ex_mask[CNT_NA_OOM] = 1'b1;
					ex_status           = ST_OOM;
				end else begin
					take               = 1'b1;
					ns_nxt             = next_slot_q + SW'(1);
					ex_mask[CNT_NA_OK] = 1'b1;
					ex_raise           = 1'b1;
				end
			end
			ACT_NODE_FREE: begin
				ex_mask[CNT_NF_CALLS] = 1'b1;
				if (slot_hit) begin
					node_clear = 1'b1;
					// With the stack full the number is dropped.
					if (!stack_full) begin
						push   = 1'b1;
						fc_nxt = free_count_q + FCW'(1);
					end
					ex_mask[CNT_NF_OK] = 1'b1;
					ex_raise           = 1'b1;
				end else begin
					ex_status = ST_NOT_FOUND;
				end
			end
			ACT_RESOLVE: begin
				ex_occ = slot_hit;
			end
			ACT_READ_COUNTER: begin
				if (sel_q < SEL_W'(NUM_CNT)) begin
					ex_cval = stat_value;
				end else begin
					ex_status = ST_INVALID;
				end
			end
			ACT_RESET_COUNTER: begin
				ex_status = ST_OK;
			end
			default: begin
				ex_status = ST_INVALID;
			end
		endcase
		if (take && (take_slot >= extent_q)) begin
			ext_nxt = take_slot + SW'(1);
		end
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			occ_we    = 1'b1;
			occ_waddr = clr_q;
			occ_wdata = 1'b0;
		end else begin
			occ_we    = (state_q == S_EXEC) && (take || node_clear);
			occ_waddr = take ? OAW'(take_slot) : OAW'(slot_q);
			occ_wdata = take;
		end
	end

	assign fs_we = (state_q == S_EXEC) && push;

	sia_ram #(
		.WIDTH(1),
		.DEPTH(SLOTS),
		.AW   (OAW)
	) u_occ_ram (
		.clk  (clk),
		.we   (occ_we),
		.waddr(occ_waddr),
		.wdata(occ_wdata),
		.re   (state_q == S_READ),
		.raddr(OAW'(slot_q)),
		.rdata(occ_rdata)
	);

	sia_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(FREE_DEPTH),
		.AW   (FAW)
	) u_free_ram (
		.clk  (clk),
		.we   (fs_we),
		.waddr(FAW'(free_count_q)),
		.wdata(slot_q),
		.re   (state_q == S_READ),
		.raddr(FAW'(free_count_q - FCW'(1))),
		.rdata(fs_rdata)
	);

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		stat_ctl.start = (state_q == S_DONE) && out_free;
		stat_ctl.clear = (state_q == S_EXEC) && (action_q == ACT_RESET_COUNTER);
		stat_ctl.mask  = mask_q;
	end

	sia_stats #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_stats (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (stat_ctl),
		.sel   (sel_q),
		.value (stat_value),
		.busy  (stat_busy)
	);

	always_comb begin
		if (hm_reset_q) begin
			hw_nxt = active;
		end else if (raise_q && (active > high_q)) begin
			hw_nxt = active;
		end else begin
			hw_nxt = high_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_backed_q <= 1'b1;
			max_active_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SLOT_BACKED: slot_backed_q <= cfg_data[0];
				CFG_MAX_ACTIVE:  max_active_q  <= cfg_data;
				default:         max_active_q  <= max_active_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			free_count_q <= '0;
			next_slot_q  <= SW'(FIRST_SLOT);
			extent_q     <= '0;
			high_q       <= '0;
			rsp_valid_q  <= 1'b0;
			mask_q       <= '0;
			raise_q      <= 1'b0;
			hm_reset_q   <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + OAW'(1);
					if (clr_q == OAW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					free_count_q <= fc_nxt;
					next_slot_q  <= ns_nxt;
					extent_q     <= ext_nxt;
					mask_q       <= ex_mask;
					raise_q      <= ex_raise;
					hm_reset_q   <= (action_q == ACT_RESET_COUNTER);
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// Hold here until the output register can take the word.
					if (out_free) begin
						high_q  <= hw_nxt;
						state_q <= S_BUMP;
					end
				end
				S_BUMP: begin
					if (!stat_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			action_q <= action_t'(action);
			slot_q   <= slot;
			sel_q    <= counter_select;
		end
		if (state_q == S_EXEC) begin
			res_status_q <= ex_status;
			res_slot_q   <= take ? SLOT_W'(take_slot) : '0;
			res_occ_q    <= ex_occ;
			res_cval_q   <= ex_cval;
		end
		if ((state_q == S_DONE) && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_slot_q   <= res_slot_q;
			rsp_occ_q    <= res_occ_q;
			rsp_cval_q   <= res_cval_q;
			rsp_active_q <= active;
			rsp_high_q   <= hw_nxt;
		end
	end

	assign req_stall     = (state_q != S_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign slot_id       = rsp_slot_q;
	assign occupied      = rsp_occ_q;
	assign counter_value = rsp_cval_q;
	assign act_w         = WW'(rsp_active_q);
	assign high_w        = WW'(rsp_high_q);
	assign active_slots  = act_w[COUNT_OUT_W-1:0];
	assign high_water    = high_w[COUNT_OUT_W-1:0];

endmodule
